>>> sv/pn9w_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pn9w_pkg
// shared types, register codes and the lfsr step function of the whitener
// ----------------------------------------------------------------------------
package pn9w_pkg;

	localparam int LFSR_W  = 16;
	localparam int COUNT_W = 12;
	localparam int DATA_W  = 8;
	localparam int CFG_W   = 16;

	localparam logic [COUNT_W-1:0] SEQUENCE_PERIOD = COUNT_W'(511);
	localparam logic [COUNT_W-1:0] COUNT_MAX       = '1;
	localparam logic [LFSR_W-1:0]  SEED_RESET      = LFSR_W'(511);
	localparam logic [COUNT_W-1:0] MAXLEN_RESET    = COUNT_W'(127);

	localparam logic REG_SEED   = 1'b0;
	localparam logic REG_MAXLEN = 1'b1;

	typedef struct packed {
		logic [LFSR_W-1:0]  lfsr;
		logic [COUNT_W-1:0] pos;
		logic [COUNT_W-1:0] cnt;
	} state_t;

	localparam state_t STATE_RESET = '{lfsr: SEED_RESET, pos: '0, cnt: '0};

	// eight steps of the right-shifting lfsr, feedback bit12 ^ bit7 into bit15
	function automatic logic [LFSR_W-1:0] pn_step8(input logic [LFSR_W-1:0] v);
		logic [LFSR_W-1:0] r;
		r = v;
		for (int k = 0; k < 8; k++) begin
			r = {r[12] ^ r[7], r[LFSR_W-1:1]};
		end
		return r;
	endfunction

endpackage

>>> sv/pn9w_state_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pn9w_state_mem
// single-entry state memory, registered read, write-back forwarding
// ----------------------------------------------------------------------------
module pn9w_state_mem (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic              wr_en,
	input  pn9w_pkg::state_t  wr_data,
	output pn9w_pkg::state_t  rd_data
);
	import pn9w_pkg::*;

	state_t mem_q [1];
	state_t rd_q;
	state_t wb_q;
	logic   init_q;
	logic   fwd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[0] <= wr_data;
			wb_q     <= wr_data;
		end
		if (rd_en) begin
			rd_q <= init_q ? mem_q[0] : STATE_RESET;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q <= 1'b0;
			fwd_q  <= 1'b0;
		end else begin
			if (wr_en) begin
				init_q <= 1'b1;
			end
			if (rd_en) begin
				fwd_q <= wr_en;
			end
		end
	end

	// entry written at the same edge as the read: take the write-back copy
	assign rd_data = fwd_q ? wb_q : rd_q;

endmodule

>>> sv/pn9w_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pn9w_core
// state update and whitening of one byte
// ----------------------------------------------------------------------------
module pn9w_core (
	input  pn9w_pkg::state_t                  cur,
	input  logic [pn9w_pkg::DATA_W-1:0]       data,
	input  logic                              start,
	input  logic [pn9w_pkg::LFSR_W-1:0]       seed,
	input  logic [pn9w_pkg::COUNT_W-1:0]      max_len,
	output pn9w_pkg::state_t                  nxt,
	output logic [pn9w_pkg::DATA_W-1:0]       whitened,
	output logic                              exceeded
);
	import pn9w_pkg::*;

	state_t             base;
	logic [LFSR_W-1:0]  lfsr8;
	logic [COUNT_W-1:0] pos_inc;

	always_comb begin
		base = cur;
		if (start) begin
			base = '{lfsr: seed, pos: '0, cnt: '0};
		end
		lfsr8    = pn_step8(base.lfsr);
		whitened = data ^ lfsr8[LFSR_W-1:LFSR_W-DATA_W];
		exceeded = base.cnt >= max_len;
		pos_inc  = base.pos + COUNT_W'(1);

		nxt.cnt = (base.cnt == COUNT_MAX) ? base.cnt : base.cnt + COUNT_W'(1);
		if (pos_inc >= SEQUENCE_PERIOD) begin
			nxt.lfsr = seed;
			nxt.pos  = '0;
		end else begin
			nxt.lfsr = lfsr8;
			nxt.pos  = pos_inc;
		end
	end

endmodule

>>> sv/pn9_byte_whitener.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pn9_byte_whitener
// pn9 whitening of a byte stream
// ----------------------------------------------------------------------------
// Takes one byte per clock unless the output stalls, and returns one whitened
// byte per byte. The rate is set by the read-modify-write of the single-entry
// state memory (lfsr, period position, byte count): the state is read at the
// input transfer, updated as the byte enters the output register and written
// back, with a forwarding path when the following byte reads at the same edge.
// No clearing pass is needed after reset. Write the configuration registers
// only while no byte is in flight.
// ----------------------------------------------------------------------------
module pn9_byte_whitener (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_addr,
	input  logic [pn9w_pkg::CFG_W-1:0]    cfg_wdata,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [7:0]                    s_axis_tdata,   // data_byte
	input  logic                          s_axis_tuser,   // packet_start
	input  logic                          s_axis_tlast,   // packet_end
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [7:0]                    m_axis_tdata,   // whitened_byte
	output logic                          m_axis_tuser,   // length_exceeded
	output logic                          m_axis_tlast    // end_of_packet
);
	import pn9w_pkg::*;

	logic [LFSR_W-1:0]  seed_q;
	logic [COUNT_W-1:0] max_len_q;

	logic               valid_s1;
	logic [DATA_W-1:0]  data_s1;
	logic               start_s1;
	logic               end_s1;

	logic               out_valid_q;
	logic [DATA_W-1:0]  out_data_q;
	logic               out_exc_q;
	logic               out_last_q;

	logic               in_xfer;
	logic               advance;
	state_t             cur_state;
	state_t             nxt_state;
	logic [DATA_W-1:0]  whitened;
	logic               exceeded;

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q    <= SEED_RESET;
			max_len_q <= MAXLEN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_SEED:   seed_q    <= cfg_wdata;
				REG_MAXLEN: max_len_q <= cfg_wdata[COUNT_W-1:0];
				default:    ;
			endcase
		end
	end

	pn9w_state_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (in_xfer),
		.wr_en   (advance),
		.wr_data (nxt_state),
		.rd_data (cur_state)
	);

	pn9w_core u_core (
		.cur      (cur_state),
		.data     (data_s1),
		.start    (start_s1),
		.seed     (seed_q),
		.max_len  (max_len_q),
		.nxt      (nxt_state),
		.whitened (whitened),
		.exceeded (exceeded)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_xfer) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			data_s1  <= s_axis_tdata;
			start_s1 <= s_axis_tuser;
			end_s1   <= s_axis_tlast;
		end
		if (advance) begin
			out_data_q <= whitened;
			out_exc_q  <= exceeded;
			out_last_q <= end_s1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_exc_q;
	assign m_axis_tlast  = out_last_q;

endmodule

>>> sv/pn9w_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pn9w_checker
// port-level checks of the whitener, bound to the top level
// ----------------------------------------------------------------------------
module pn9w_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_axis_tvalid,
	input logic       s_axis_tready,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata,
	input logic       m_axis_tuser,
	input logic       m_axis_tlast
);
	logic       in_xfer;
	logic       out_xfer;
	logic [2:0] pend_q;

	assign in_xfer  = s_axis_tvalid && s_axis_tready;
	assign out_xfer = m_axis_tvalid && m_axis_tready;

	// bytes taken but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 3'(in_xfer) - 3'(out_xfer);
		end
	end

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("output valid dropped while stalled");

	a_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			$stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("output payload changed while stalled");

	a_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 3'd2)
		else $error("more than two bytes in flight");

	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> pend_q != 3'd0)
		else $error("output without a pending input");

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q == 3'd0 |-> s_axis_tready)
		else $error("input not ready while empty");

endmodule

bind pn9_byte_whitener pn9w_checker u_pn9w_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);
